// ===== hw/rtl/sm3_pkg.sv =====
`timescale 1ns / 1ps

package sm3_pkg;

  localparam int WordWidth = 32;
  localparam int BlockWords = 16;
  localparam int Rounds = 64;
  localparam int DigestWords = 8;
  localparam int CountWidth = 61;
  localparam int FifoDepthDefault = 4;

  localparam logic [31:0] TLow = 32'h79CC4519;
  localparam logic [31:0] THigh = 32'h7A879D8A;
  localparam logic [7:0] PadMark = 8'h80;

  typedef struct packed {
    logic [31:0] message_word;
    logic        final_word;
    logic [2:0]  valid_bytes;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_word_t;

  // Block handed from the front part to the compression engine.
  typedef struct packed {
    logic [BlockWords*32-1:0] block;
    logic                     last;
  } blk_job_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_EXPAND,
    ENG_ROUND,
    ENG_EMIT
  } eng_state_t;

  typedef enum logic [1:0] {
    FR_GATHER,
    FR_PAD2
  } front_state_t;

  function automatic logic [31:0] init_value(input logic [2:0] i);
    logic [31:0] v;
    unique case (i)
      3'd0: v = 32'h7380166F;
      3'd1: v = 32'h4914B2B9;
      3'd2: v = 32'h172442D7;
      3'd3: v = 32'hDA8A0600;
      3'd4: v = 32'hA96F30BC;
      3'd5: v = 32'h163138AA;
      3'd6: v = 32'hE38DEE4D;
      default: v = 32'hB0FB0E4E;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ===== hw/rtl/sm3_front.sv =====
`timescale 1ns / 1ps

module sm3_front (
  input  logic               clk,
  input  logic               rst,
  input  sm3_pkg::in_word_t  in_word,
  input  logic               in_valid,
  output logic               in_ready,
  output sm3_pkg::blk_job_t  job,
  output logic               job_valid,
  input  logic               job_ready
);
  import sm3_pkg::*;

  logic [31:0]           buffer [BlockWords];
  logic [3:0]            words_in_block;
  logic [CountWidth-1:0] byte_count;
  front_state_t          state;
  logic [CountWidth-1:0] pad_count;
  logic                  pos_was_full;

  logic [2:0]            nbytes;
  logic [31:0]           tail_word;
  logic [CountWidth-1:0] count_sum;
  logic [6:0]            pos;
  logic                  accept;
  logic [BlockWords*32-1:0] flat_now;
  logic [BlockWords*32-1:0] fin_block;
  logic                  needs_two;
  logic [31:0]           mask;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == FR_GATHER) && job_ready;

  // Saturate the byte count of a final word and build its padded form.
  always_comb begin
    nbytes = in_word.final_word ? ((in_word.valid_bytes > 3'd4) ? 3'd4 : in_word.valid_bytes)
                                : 3'd4;
    count_sum = byte_count + CountWidth'(nbytes);
    mask = ~(32'hFFFFFFFF >> {nbytes, 3'b000});
    if (nbytes == 3'd4) mask = 32'hFFFFFFFF;
    tail_word = in_word.message_word & mask;
    if (nbytes != 3'd4) begin
      tail_word = tail_word | (32'({PadMark}) << (5'd24 - {nbytes[1:0], 3'b000}));
    end
    pos = {1'b0, words_in_block, 2'b00} + 7'(nbytes);
    needs_two = (pos >= 7'd56);
  end

  // Assemble the block that leaves with this word.
  always_comb begin
    for (int i = 0; i < BlockWords; i++) begin
      flat_now[(BlockWords-1-i)*32 +: 32] = buffer[i];
      if (4'(i) == words_in_block) flat_now[(BlockWords-1-i)*32 +: 32] = in_word.message_word;
      if (4'(i) == words_in_block) fin_block[(BlockWords-1-i)*32 +: 32] = tail_word;
      else if (4'(i) > words_in_block) fin_block[(BlockWords-1-i)*32 +: 32] =
          ((4'(i) == words_in_block + 4'd1) && (nbytes == 3'd4)) ? {PadMark, 24'd0} : 32'd0;
      else fin_block[(BlockWords-1-i)*32 +: 32] = buffer[i];
    end
    if (!needs_two) begin
      fin_block[63:32] = count_sum[CountWidth-1:29];
      fin_block[31:0] = {count_sum[28:0], 3'b000};
    end
  end

  // Hand blocks to the queue.
  always_comb begin
    job = '0;
    job_valid = 1'b0;
    if (state == FR_PAD2) begin
      job_valid = 1'b1;
      job.last = 1'b1;
      job.block = '0;
      if (pos_was_full) job.block[BlockWords*32-1 -: 32] = {PadMark, 24'd0};
      job.block[63:32] = pad_count[CountWidth-1:29];
      job.block[31:0] = {pad_count[28:0], 3'b000};
    end else if (accept && in_word.final_word) begin
      job_valid = 1'b1;
      job.block = fin_block;
      job.last = !needs_two;
    end else if (accept && words_in_block == 4'd15) begin
      job_valid = 1'b1;
      job.block = flat_now;
    end
  end

  // Gather words and track the message length.
  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_block <= '0;
      byte_count <= '0;
      state <= FR_GATHER;
      pos_was_full <= 1'b0;
    end else if (state == FR_PAD2) begin
      if (job_ready) state <= FR_GATHER;
    end else if (accept) begin
      if (in_word.final_word) begin
        words_in_block <= '0;
        byte_count <= '0;
        if (needs_two) begin
          state <= FR_PAD2;
          pos_was_full <= (pos == 7'd64);
          pad_count <= count_sum;
        end
      end else begin
        words_in_block <= words_in_block + 4'd1;
        byte_count <= count_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_word.final_word) buffer[words_in_block] <= in_word.message_word;
  end

endmodule

// ===== hw/rtl/sm3_fifo.sv =====
`timescale 1ns / 1ps

module sm3_fifo #(
  parameter int Depth = sm3_pkg::FifoDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  sm3_pkg::blk_job_t wr_data,
  input  logic              wr_valid,
  output logic              wr_ready,
  output sm3_pkg::blk_job_t rd_data,
  output logic              rd_valid,
  input  logic              rd_ready
);
  import sm3_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  blk_job_t mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign wr_ready = (count != (AW+1)'(Depth));
  assign rd_valid = (count != '0);
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;
  assign rd_data = mem[rd_ptr];

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

// ===== hw/rtl/sm3_engine.sv =====
`timescale 1ns / 1ps

module sm3_engine (
  input  logic               clk,
  input  logic               rst,
  input  sm3_pkg::blk_job_t  job,
  input  logic               job_valid,
  output logic               job_ready,
  output sm3_pkg::out_word_t out_word,
  output logic               out_valid,
  input  logic               out_ready
);
  import sm3_pkg::*;

  eng_state_t state, state_next;
  logic [31:0] cv [DigestWords];
  logic [31:0] r [DigestWords];
  logic [31:0] w [BlockWords];
  logic [5:0]  round_number;
  logic [2:0]  emit_idx;
  logic        last;

  logic [31:0] a12, t_rot, ss1, ss2, ff, gg, tt1, tt2, w_new, w4;

  // One round per cycle; W runs as a sliding window of sixteen words.
  always_comb begin
    a12 = rotl(r[0], 5'd12);
    t_rot = rotl((round_number < 6'd16) ? TLow : THigh, round_number[4:0]);
    ss1 = rotl(a12 + r[4] + t_rot, 5'd7);
    ss2 = ss1 ^ a12;
    if (round_number < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    w4 = w[4];
    tt1 = ff + r[3] + ss2 + (w[0] ^ w4);
    tt2 = gg + r[7] + ss1 + w[0];
    w_new = perm1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  end

  assign job_ready = (state == ENG_IDLE);
  assign out_valid = (state == ENG_EMIT);
  assign out_word.digest_word = cv[emit_idx];
  assign out_word.digest_index = emit_idx;
  assign out_word.digest_last = (emit_idx == 3'd7);

  // Sequencer: load, 64 rounds, fold, optional digest output.
  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE:   if (job_valid) state_next = ENG_ROUND;
      ENG_ROUND:  if (round_number == 6'd63) state_next = last ? ENG_EMIT : ENG_IDLE;
      ENG_EMIT:   if (out_ready && emit_idx == 3'd7) state_next = ENG_IDLE;
      default:    state_next = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
      round_number <= '0;
      emit_idx <= '0;
      for (int i = 0; i < DigestWords; i++) cv[i] <= init_value(3'(i));
    end else begin
      state <= state_next;
      unique case (state)
        ENG_IDLE: begin
          round_number <= '0;
          emit_idx <= '0;
        end
        ENG_ROUND: begin
          round_number <= round_number + 6'd1;
          if (round_number == 6'd63) begin
            for (int i = 0; i < DigestWords; i++) cv[i] <= cv[i] ^ rnext(i);
          end
        end
        ENG_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < DigestWords; i++) cv[i] <= init_value(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

  function automatic logic [31:0] rnext(input int i);
    logic [31:0] v;
    unique case (i)
      0: v = tt1;
      1: v = r[0];
      2: v = rotl(r[1], 5'd9);
      3: v = r[2];
      4: v = perm0(tt2);
      5: v = r[4];
      6: v = rotl(r[5], 5'd19);
      default: v = r[6];
    endcase
    return v;
  endfunction

  // Working registers and message window.
  always_ff @(posedge clk) begin
    if (state == ENG_IDLE && job_valid) begin
      last <= job.last;
      for (int i = 0; i < DigestWords; i++) r[i] <= cv[i];
      for (int i = 0; i < BlockWords; i++) w[i] <= job.block[(BlockWords-1-i)*32 +: 32];
    end else if (state == ENG_ROUND) begin
      for (int i = 0; i < DigestWords; i++) r[i] <= rnext(i);
      for (int i = 0; i < BlockWords-1; i++) w[i] <= w[i+1];
      w[BlockWords-1] <= w_new;
    end
  end

endmodule

// ===== hw/rtl/sm3_hash_stream.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake
// in      | input     | push / full
// out     | output    | pop / empty
// A block of 16 words is compressed by the one-round-per-cycle engine, which
// takes no new block from the queue until it has finished the last.
// The final word adds one or two blocks, then eight digest words leave one per pop.
// rst is synchronous; the chaining value returns to the initial value.
// A block queue (four entries by default) lets the front gather while the engine works; full
// rises while that queue is full or a second padding block waits to enter it.
module sm3_hash_stream #(
  parameter int FifoDepth = sm3_pkg::FifoDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  sm3_pkg::in_word_t  in_data,
  input  logic               push,
  output logic               full,
  output sm3_pkg::out_word_t out_data,
  output logic               empty,
  input  logic               pop
);
  import sm3_pkg::*;

  blk_job_t f_job, e_job;
  logic f_valid, f_ready, e_valid, e_ready, in_ready, out_valid;

  sm3_front u_front (
    .clk, .rst, .in_word(in_data), .in_valid(push), .in_ready,
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  sm3_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk, .rst, .wr_data(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(e_job), .rd_valid(e_valid), .rd_ready(e_ready)
  );

  sm3_engine u_engine (
    .clk, .rst, .job(e_job), .job_valid(e_valid), .job_ready(e_ready),
    .out_word(out_data), .out_valid, .out_ready(pop)
  );

  assign full = !in_ready;
  assign empty = !out_valid;

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> (out_data.digest_index == $past(out_data.digest_index) + 3'd1))
    else $error("digest index skipped");
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_data.digest_last == (out_data.digest_index == 3'd7)))
    else $error("digest last mismatch");

endmodule
